>>> rtl/fba_pkg.sv
// Shared types and codes of the fit block allocator.
package fba_pkg;

  // Input transaction: command and size.
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] size_value;
  } in_item_t;

  // Result transaction: status, block index and size before the allocation.
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  block_index;
    logic [15:0] size_before;
  } out_item_t;

  // Control part of the search token that runs along the cell chain.
  typedef struct packed {
    logic valid;
    logic found;
  } tok_ctl_t;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;

  localparam logic [2:0] ST_LOADED    = 3'd0;
  localparam logic [2:0] ST_ALLOCATED = 3'd1;
  localparam logic [2:0] ST_NOFIT     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_CLEARED   = 3'd4;

endpackage

>>> rtl/fba_cell.sv
// One table entry of the allocator with its stage of the search chain.
module fba_cell #(
  parameter int SIZE_BITS = 16,
  parameter int IDX_W     = 4,
  parameter int CELL_IDX  = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           mode,
  input  logic                 active,
  input  logic [SIZE_BITS-1:0] req,
  input  logic                 ld_en,
  input  logic [IDX_W-1:0]     ld_idx,
  input  logic [SIZE_BITS-1:0] ld_data,
  input  logic                 commit,
  input  logic [IDX_W-1:0]     commit_idx,
  input  fba_pkg::tok_ctl_t    tin_ctl,
  input  logic [IDX_W-1:0]     tin_pick,
  input  logic [SIZE_BITS-1:0] tin_size,
  output fba_pkg::tok_ctl_t    tout_ctl,
  output logic [IDX_W-1:0]     tout_pick,
  output logic [SIZE_BITS-1:0] tout_size
);
  import fba_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [SIZE_BITS-1:0] size_r;
  tok_ctl_t             ctl_r;
  logic [IDX_W-1:0]     pick_r;
  logic [SIZE_BITS-1:0] psize_r;
  logic                 fits;
  logic                 better;
  logic                 take;

  always_comb begin
    fits = active && (req <= size_r);
    case (mode)
      MODE_BEST:  better = size_r < tin_size;
      MODE_WORST: better = size_r > tin_size;
      default:    better = 1'b0;
    endcase
    take = tin_ctl.valid && fits && (!tin_ctl.found || better);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r.valid <= tin_ctl.valid;
      ctl_r.found <= tin_ctl.found || take;
    end
  end

  always_ff @(posedge clk) begin
    pick_r  <= take ? MY_IDX : tin_pick;
    psize_r <= take ? size_r : tin_size;
    if (ld_en && ld_idx == MY_IDX) begin
      size_r <= ld_data;
    end else if (commit && commit_idx == MY_IDX) begin
      size_r <= size_r - req;
    end
  end

  assign tout_ctl  = ctl_r;
  assign tout_pick = pick_r;
  assign tout_size = psize_r;

endmodule

>>> rtl/fit_block_allocator_top.sv
// Top level of the fit block allocator: command decode, table count and cell chain.
// Load and clear: result in the cycle after acceptance, busy stays low, one per cycle.
// Allocate: busy while the search token walks the cell
//   chain one cell per clock; the result shows in the first cycle with busy low.
// Reset (rst_n low, synchronous) empties the table and selects first fit.
// Results are one-cycle strobes; the receiver cannot stall them.
module fit_block_allocator_top #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  fba_pkg::in_item_t  in_data,
  output logic               out_valid,
  output fba_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data
);
  import fba_pkg::*;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_BLOCKS);

  // Control and table count.
  logic                 busy_r;
  logic                 launch_r;
  logic [SIZE_BITS-1:0] req_r;
  logic [CNT_W-1:0]     count_r;
  logic [1:0]           mode_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  // Search token chain: entry 0 feeds the first cell, entry MAX_BLOCKS leaves the last.
  tok_ctl_t             tok_ctl  [0:MAX_BLOCKS];
  logic [IDX_W-1:0]     tok_pick [0:MAX_BLOCKS];
  logic [SIZE_BITS-1:0] tok_size [0:MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] tok_vld;
  logic [MAX_BLOCKS-1:0] active;

  logic                 accept;
  logic                 full;
  logic                 ld_en;
  logic [SIZE_BITS-1:0] in_size;
  logic                 commit;

  assign accept  = start && !busy_r;
  assign full    = (count_r == FULL_CNT);
  assign in_size = SIZE_BITS'(in_data.size_value);
  assign ld_en   = accept && (in_data.command == CMD_LOAD) && !full;
  // The token leaving the last cell closes the search and writes back the winner.
  assign commit  = tok_ctl[MAX_BLOCKS].valid;

  assign tok_ctl[0]  = '{valid: launch_r, found: 1'b0};
  assign tok_pick[0] = '0;
  assign tok_size[0] = '0;

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    // Only entries below the count take part in a search.
    assign active[i]  = count_r > CNT_W'(i);
    assign tok_vld[i] = tok_ctl[i+1].valid;

    fba_cell #(
      .SIZE_BITS (SIZE_BITS),
      .IDX_W     (IDX_W),
      .CELL_IDX  (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .mode       (mode_r),
      .active     (active[i]),
      .req        (req_r),
      .ld_en      (ld_en),
      .ld_idx     (count_r[IDX_W-1:0]),
      .ld_data    (in_size),
      .commit     (commit && tok_ctl[MAX_BLOCKS].found),
      .commit_idx (tok_pick[MAX_BLOCKS]),
      .tin_ctl    (tok_ctl[i]),
      .tin_pick   (tok_pick[i]),
      .tin_size   (tok_size[i]),
      .tout_ctl   (tok_ctl[i+1]),
      .tout_pick  (tok_pick[i+1]),
      .tout_size  (tok_size[i+1])
    );
  end

  // Configuration: the mode register takes a write at any time.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FIRST;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  // Command decode, count update and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      launch_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      launch_r    <= 1'b0;
      if (accept) begin
        out_valid_r <= 1'b1;
        case (in_data.command)
          CMD_LOAD: begin
            if (full) begin
              out_data_r <= '{status: ST_FULL, block_index: '0, size_before: '0};
            end else begin
              out_data_r <= '{status: ST_LOADED, block_index: 4'(count_r),
                              size_before: '0};
              count_r    <= count_r + CNT_W'(1);
            end
          end
          CMD_ALLOC: begin
            // Hold the request and launch the token; the result comes at commit.
            out_valid_r <= 1'b0;
            busy_r      <= 1'b1;
            launch_r    <= 1'b1;
            req_r       <= in_size;
          end
          default: begin
            count_r    <= '0;
            out_data_r <= '{status: ST_CLEARED, block_index: '0, size_before: '0};
          end
        endcase
      end else if (commit) begin
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
        if (tok_ctl[MAX_BLOCKS].found) begin
          out_data_r <= '{status: ST_ALLOCATED, block_index: 4'(tok_pick[MAX_BLOCKS]),
                          size_before: 16'(tok_size[MAX_BLOCKS])};
        end else begin
          out_data_r <= '{status: ST_NOFIT, block_index: '0, size_before: '0};
        end
      end
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // At most one search token lives in the chain.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({launch_r, tok_vld}))
    else $error("more than one search token in the cell chain");

  // A token only travels while an allocation is in progress.
  a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> busy_r)
    else $error("search token leaves the chain while idle");

  // Finishing an allocation always delivers a result.
  a_alloc_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy_r) && $past(rst_n)) |-> out_valid_r)
    else $error("allocation finished without a result");

  // The count never passes the table depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("block count beyond table depth");

endmodule
